### design/rc_receiver_hop_and_packet_filter_top_macros.svh
// assertion macros used by the receiver checker
`ifndef RC_RECEIVER_HOP_AND_PACKET_FILTER_TOP_MACROS_SVH
`define RC_RECEIVER_HOP_AND_PACKET_FILTER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RCHF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RCHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rchf_pkg.sv
// types, constants and hop table of the hopping receiver
`timescale 1ns / 1ps

package rchf_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 16;
    localparam int COL_W        = 4;
    localparam int ROW_W        = 4;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int IN_DATA_W    = 160;
    localparam int IN_USER_W    = 3;
    localparam int OUT_DATA_W   = 136;
    localparam int OUT_USER_W   = 2;

    // item kinds
    localparam logic [1:0] KIND_SLOT   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_PACKET = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BOUND_ID   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FS_LOW     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FS_HIGH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_EN  = 3'd4;

    localparam logic [15:0] LOSS_LIMIT_RESET = 16'd800;
    localparam logic [15:0] LOSS_TICKS_MAX   = 16'hFFFF;
    localparam logic [3:0]  OFFSET_CAP       = 4'd9;
    localparam logic [7:0]  CH_HIGH_MIN      = 8'd3;
    localparam logic [7:0]  CH_HIGH_MAX      = 8'd8;
    localparam logic [CH_W-1:0] CH_RESET_DEFAULT  = 16'd1500;
    localparam logic [CH_W-1:0] CH_RESET_THROTTLE = 16'd1000;

    typedef logic [MAX_CHANNELS-1:0][CH_W-1:0] ch_vec_t;

    // per-item control from the hop/timeout unit to the lanes
    typedef struct packed {
        logic step;
        logic load_fs;
        logic take_pkt;
    } lane_ctrl_t;

    localparam logic [7:0] HOP_TABLE [0:15][0:15] = '{
        '{8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,
          8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0},
        '{8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,
          8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a},
        '{8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,
          8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82},
        '{8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,
          8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a},
        '{8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,
          8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96},
        '{8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,
          8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28},
        '{8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,
          8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64},
        '{8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,
          8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50},
        '{8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,
          8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64},
        '{8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,
          8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50},
        '{8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,
          8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
        '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,
          8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46},
        '{8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,
          8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82},
        '{8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,
          8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46},
        '{8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,
          8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
        '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,
          8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46}
    };

    // reset value of one channel: the throttle channel starts low
    function automatic logic [CH_W-1:0] ch_reset_value(input int idx);
        return (idx == 2) ? CH_RESET_THROTTLE : CH_RESET_DEFAULT;
    endfunction

endpackage

### design/rchf_hop_ctrl.sv
// hop column, rf channel, loss timeout and packet filter
`timescale 1ns / 1ps

module rchf_hop_ctrl
    import rchf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [1:0]  kind,
    input  logic        rx_error,
    input  logic [31:0] packet_id,
    input  logic [31:0] bound_tx_id,
    input  logic [15:0] loss_limit,
    input  logic        update_en,
    output lane_ctrl_t  lane_ctrl,
    output logic [7:0]  rf_next,
    output logic        accepted,
    output logic        in_fs_next
);

    logic [COL_W-1:0] hop_column_reg, hop_column_next;
    logic [15:0]      loss_ticks_reg, loss_ticks_next;
    logic [7:0]       rf_reg;
    logic [15:0]      loss_mid;
    logic [3:0]       offset;
    logic [ROW_W-1:0] row;
    logic             pass;

    // hop row and capped offset from the bound id
    assign row    = bound_tx_id[ROW_W-1:0];
    assign offset = (bound_tx_id[7:4] > OFFSET_CAP) ? OFFSET_CAP : bound_tx_id[7:4];

    // next state for one item
    always_comb begin
        hop_column_next = hop_column_reg;
        loss_mid        = loss_ticks_reg;
        rf_next         = rf_reg;
        unique case (kind)
            KIND_SLOT: begin
                rf_next = HOP_TABLE[row][hop_column_reg] - {4'd0, offset} - 8'd1;
                hop_column_next = hop_column_reg + 1'b1;
            end
            KIND_TICK: begin
                loss_mid = (loss_ticks_reg == LOSS_TICKS_MAX) ? loss_ticks_reg
                                                              : loss_ticks_reg + 16'd1;
                hop_column_next = hop_column_reg + 1'b1;
            end
            KIND_PACKET, KIND_NONE: begin
            end
            default: begin
            end
        endcase
        pass            = (kind == KIND_PACKET) && !rx_error && (packet_id == bound_tx_id);
        loss_ticks_next = pass ? 16'd0 : loss_mid;
        accepted        = pass;
        in_fs_next      = loss_ticks_next > loss_limit;
        lane_ctrl.step     = step;
        lane_ctrl.load_fs  = (kind != KIND_NONE) && (loss_mid > loss_limit);
        lane_ctrl.take_pkt = pass && update_en;
    end

    // state registers, updated per accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_column_reg <= '0;
            loss_ticks_reg <= '0;
            rf_reg         <= '0;
        end else if (step) begin
            hop_column_reg <= hop_column_next;
            loss_ticks_reg <= loss_ticks_next;
            rf_reg         <= rf_next;
        end
    end

endmodule

### design/rchf_lane.sv
// one channel lane: failsafe load and range-checked packet update
`timescale 1ns / 1ps

module rchf_lane
    import rchf_pkg::*;
#(
    parameter logic [15:0] RESET_VALUE = 16'd1500
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  lane_ctrl_t      lane_ctrl,
    input  logic [CH_W-1:0] fs_value,
    input  logic [CH_W-1:0] pkt_value,
    output logic [CH_W-1:0] value_next
);

    logic [CH_W-1:0] value_reg;
    logic            in_range;

    assign in_range = (pkt_value[15:8] >= CH_HIGH_MIN) && (pkt_value[15:8] <= CH_HIGH_MAX);

    // packet value wins over failsafe load within the same item
    always_comb begin
        value_next = value_reg;
        if (lane_ctrl.step) begin
            if (lane_ctrl.load_fs) begin
                value_next = fs_value;
            end
            if (lane_ctrl.take_pkt && in_range) begin
                value_next = pkt_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= RESET_VALUE;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

### design/rchf_out_stage.sv
// merge of lane values and the output register
`timescale 1ns / 1ps

module rchf_out_stage
    import rchf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic [7:0]            rf_channel,
    input  ch_vec_t               ch_vec,
    input  logic                  accepted,
    input  logic                  in_fs,
    output logic                  space,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [OUT_USER_W-1:0] user_reg;

    // room for a new result when empty or the held one leaves now
    assign space = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload: rf channel, channels 0..3, channels 4..7
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {ch_vec[7:4], ch_vec[3:0], rf_channel};
            user_reg <= {in_fs, accepted};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

### design/rc_receiver_hop_and_packet_filter_top.sv
// top level of the hopping receiver with packet filter
//
// Input stream s_*: one transfer per event. s_tuser carries the kind (slot
// start, timer tick, received packet or none) and the radio error flag; s_tdata
// carries the packet id and the eight packet channel values.
// Output stream m_*: exactly one result transfer per input transfer, in
// order: rf channel, the eight current channel values, the packet accepted
// flag and the failsafe flag.
// A result is registered and is valid the cycle after its input transfer.
// One item per cycle while not stalled; the loss counter, hop column and all
// channel lanes update in the accepting cycle, so items run back to back.
// When the output is stalled, s_tready stays high only while the output
// register is empty; a held result stays put until m_tready.
// Reset (aresetn low, synchronous): hop column, loss counter and rf channel
// clear, channels return to 1500 (channel 2 to 1000), the loss limit to 800
// and updates are enabled. Configuration writes on cfg_* take effect at once;
// the user must do them only while the block is idle (not enforced).
`timescale 1ns / 1ps

module rc_receiver_hop_and_packet_filter_top
    import rchf_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // packet_id, packet_ch_low, packet_ch_high
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind, rx_error
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rf_channel, channels_low, channels_high
    output logic [OUT_DATA_W-1:0] m_tdata,
    // packet_accepted, in_failsafe
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic [31:0] bound_tx_id_reg;
    logic [63:0] fs_low_reg;
    logic [63:0] fs_high_reg;
    logic [15:0] loss_limit_reg;
    logic        update_en_reg;

    logic        step;
    lane_ctrl_t  lane_ctrl;
    logic [7:0]  rf_next;
    logic        accepted;
    logic        in_fs_next;
    ch_vec_t     ch_vec;
    ch_vec_t     fs_vec;
    ch_vec_t     pkt_vec;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_tx_id_reg <= '0;
            fs_low_reg      <= '0;
            fs_high_reg     <= '0;
            loss_limit_reg  <= LOSS_LIMIT_RESET;
            update_en_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_BOUND_ID:   bound_tx_id_reg <= cfg_wdata[31:0];
                CFG_FS_LOW:     fs_low_reg      <= cfg_wdata;
                CFG_FS_HIGH:    fs_high_reg     <= cfg_wdata;
                CFG_LOSS_LIMIT: loss_limit_reg  <= cfg_wdata[15:0];
                CFG_UPDATE_EN:  update_en_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign step    = s_tvalid && s_tready;
    assign fs_vec  = {fs_high_reg, fs_low_reg};
    assign pkt_vec = s_tdata[159:32];

    rchf_hop_ctrl u_hop_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (s_tuser[1:0]),
        .rx_error    (s_tuser[2]),
        .packet_id   (s_tdata[31:0]),
        .bound_tx_id (bound_tx_id_reg),
        .loss_limit  (loss_limit_reg),
        .update_en   (update_en_reg),
        .lane_ctrl   (lane_ctrl),
        .rf_next     (rf_next),
        .accepted    (accepted),
        .in_fs_next  (in_fs_next)
    );

    // channel lanes; unused channels read as zero
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
        if (i < NUM_CHANNELS) begin : g_used
            rchf_lane #(
                .RESET_VALUE (ch_reset_value(i))
            ) u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .lane_ctrl  (lane_ctrl),
                .fs_value   (fs_vec[i]),
                .pkt_value  (pkt_vec[i]),
                .value_next (ch_vec[i])
            );
        end else begin : g_unused
            assign ch_vec[i] = '0;
        end
    end

    rchf_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .rf_channel (rf_next),
        .ch_vec     (ch_vec),
        .accepted   (accepted),
        .in_fs      (in_fs_next),
        .space      (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### design/rchf_checker.sv
// port-level checks of the hopping receiver, bound to the top level
`timescale 1ns / 1ps
`include "rc_receiver_hop_and_packet_filter_top_macros.svh"

module rchf_checker
    import rchf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_USER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // a stalled result holds
    `RCHF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // every input transfer shows a result next cycle
    `RCHF_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_tvalid && s_tready, m_tvalid, "no result after input transfer")

    // only packets can be accepted
    `RCHF_ASSERT_NEXT(a_accept_kind, aclk, aresetn, s_tvalid && s_tready && (s_tuser[1:0] != KIND_PACKET), !m_tuser[0], "non-packet marked accepted")

    // an accepted packet clears the timeout
    `RCHF_ASSERT_SAME(a_accept_no_fs, aclk, aresetn, m_tvalid && m_tuser[0], !m_tuser[1], "failsafe after accepted packet")

endmodule

bind rc_receiver_hop_and_packet_filter_top rchf_checker u_rchf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/tb_rc_receiver_hop_and_packet_filter_top.sv
// self-checking bench for the hopping receiver: hop channel, loss timeout and packet filter
`timescale 1ns / 1ps

module tb_rc_receiver_hop_and_packet_filter_top;
    import rchf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;

    // channel words after reset, and with every lane at 0x0300
    localparam logic [63:0] RST_CH_LOW  = 64'h05DC_03E8_05DC_05DC;
    localparam logic [63:0] RST_CH_HIGH = 64'h05DC_05DC_05DC_05DC;
    localparam logic [63:0] LANES_0300  = 64'h0300_0300_0300_0300;

    // hop sequence per transmitter row
    localparam logic [7:0] HOP_ROM [16][16] = '{
        '{8'h0a,8'h5a,8'h14,8'h64,8'h1e,8'h6e,8'h28,8'h78,
          8'h32,8'h82,8'h3c,8'h8c,8'h46,8'h96,8'h50,8'ha0},
        '{8'ha0,8'h50,8'h96,8'h46,8'h8c,8'h3c,8'h82,8'h32,
          8'h78,8'h28,8'h6e,8'h1e,8'h64,8'h14,8'h5a,8'h0a},
        '{8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,8'h46,8'h96,
          8'h1e,8'h6e,8'h3c,8'h8c,8'h28,8'h78,8'h32,8'h82},
        '{8'h82,8'h32,8'h78,8'h28,8'h8c,8'h3c,8'h6e,8'h1e,
          8'h96,8'h46,8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a},
        '{8'h28,8'h78,8'h0a,8'h5a,8'h50,8'ha0,8'h14,8'h64,
          8'h1e,8'h6e,8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96},
        '{8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,8'h6e,8'h1e,
          8'h64,8'h14,8'ha0,8'h50,8'h5a,8'h0a,8'h78,8'h28},
        '{8'h50,8'ha0,8'h28,8'h78,8'h0a,8'h5a,8'h1e,8'h6e,
          8'h3c,8'h8c,8'h32,8'h82,8'h46,8'h96,8'h14,8'h64},
        '{8'h64,8'h14,8'h96,8'h46,8'h82,8'h32,8'h8c,8'h3c,
          8'h6e,8'h1e,8'h5a,8'h0a,8'h78,8'h28,8'ha0,8'h50},
        '{8'h50,8'ha0,8'h46,8'h96,8'h3c,8'h8c,8'h28,8'h78,
          8'h0a,8'h5a,8'h32,8'h82,8'h1e,8'h6e,8'h14,8'h64},
        '{8'h64,8'h14,8'h6e,8'h1e,8'h82,8'h32,8'h5a,8'h0a,
          8'h78,8'h28,8'h8c,8'h3c,8'h96,8'h46,8'ha0,8'h50},
        '{8'h46,8'h96,8'h3c,8'h8c,8'h50,8'ha0,8'h28,8'h78,
          8'h0a,8'h5a,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
        '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h5a,8'h0a,
          8'h78,8'h28,8'ha0,8'h50,8'h8c,8'h3c,8'h96,8'h46},
        '{8'h46,8'h96,8'h0a,8'h5a,8'h3c,8'h8c,8'h14,8'h64,
          8'h50,8'ha0,8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82},
        '{8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,8'ha0,8'h50,
          8'h64,8'h14,8'h8c,8'h3c,8'h5a,8'h0a,8'h96,8'h46},
        '{8'h46,8'h96,8'h0a,8'h5a,8'h50,8'ha0,8'h3c,8'h8c,
          8'h28,8'h78,8'h1e,8'h6e,8'h32,8'h82,8'h14,8'h64},
        '{8'h64,8'h14,8'h82,8'h32,8'h6e,8'h1e,8'h78,8'h28,
          8'h8c,8'h3c,8'ha0,8'h50,8'h5a,8'h0a,8'h96,8'h46}
    };

    typedef struct packed {
        logic [7:0]  rf_channel;
        logic [63:0] channels_low;
        logic [63:0] channels_high;
        logic        packet_accepted;
        logic        in_failsafe;
    } rx_status_t;

    // one line of the directed plan: a register write or an event
    typedef struct {
        logic                  is_write;
        logic [CFG_ADDR_W-1:0] addr;
        logic [63:0]           wdata;
        logic [1:0]            kind;
        logic                  rx_error;
        logic [31:0]           packet_id;
        logic [63:0]           ch_low;
        logic [63:0]           ch_high;
        logic                  pinned;
        rx_status_t            status;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // packet_id, packet_ch_low, packet_ch_high
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // kind, rx_error
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // rf_channel, channels_low, channels_high
    logic [OUT_DATA_W-1:0] m_tdata;
    // packet_accepted, in_failsafe
    logic [OUT_USER_W-1:0] m_tuser;

    // receiver copy: configuration
    logic [31:0] rx_bound_id;
    logic [63:0] rx_fs_low;
    logic [63:0] rx_fs_high;
    logic [15:0] rx_loss_limit;
    logic        rx_update_en;
    // receiver copy: state
    logic [3:0]  rx_hop_col;
    logic [15:0] rx_loss_ticks;
    logic [7:0]  rx_rf;
    logic [15:0] rx_ch [8];

    rx_status_t  status_due [$];
    plan_row_t   plan [$];
    logic        pin_now = 1'b0;
    rx_status_t  pin_status;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    rc_receiver_hop_and_packet_filter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // state of the receiver after reset
    task automatic clear_receiver();
        rx_bound_id   = '0;
        rx_fs_low     = '0;
        rx_fs_high    = '0;
        rx_loss_limit = 16'd800;
        rx_update_en  = 1'b1;
        rx_hop_col    = '0;
        rx_loss_ticks = '0;
        rx_rf         = '0;
        for (int i = 0; i < 8; i++) begin
            rx_ch[i] = (i == 2) ? 16'd1000 : 16'd1500;
        end
    endtask

    // hop, timeout and packet filter for one event; returns the status it reports
    function automatic rx_status_t receiver_step(input logic [1:0] kind, input logic err,
                                                 input logic [31:0] pid,
                                                 input logic [63:0] lo, input logic [63:0] hi);
        rx_status_t  res;
        logic [3:0]  offset;
        logic [15:0] lane;
        logic [127:0] pkt_lanes;
        logic [127:0] fs_lanes;
        logic        accepted;
        accepted  = 1'b0;
        pkt_lanes = {hi, lo};
        fs_lanes  = {rx_fs_high, rx_fs_low};
        if (kind == KIND_SLOT) begin
            offset = (rx_bound_id[7:4] > 4'd9) ? 4'd9 : rx_bound_id[7:4];
            rx_rf = HOP_ROM[rx_bound_id[3:0]][rx_hop_col] - {4'd0, offset} - 8'd1;
            rx_hop_col = rx_hop_col + 4'd1;
        end else if (kind == KIND_TICK) begin
            if (rx_loss_ticks != 16'hFFFF) begin
                rx_loss_ticks = rx_loss_ticks + 16'd1;
            end
            rx_hop_col = rx_hop_col + 4'd1;
        end
        // timeout: every lane falls back to its failsafe value
        if (kind != KIND_NONE && rx_loss_ticks > rx_loss_limit) begin
            for (int i = 0; i < 8; i++) begin
                rx_ch[i] = fs_lanes[16*i +: 16];
            end
        end
        // packet filter: clean status and all four id bytes equal
        if (kind == KIND_PACKET && !err && pid == rx_bound_id) begin
            accepted = 1'b1;
            rx_loss_ticks = '0;
            if (rx_update_en) begin
                for (int i = 0; i < 8; i++) begin
                    lane = pkt_lanes[16*i +: 16];
                    if (lane[15:8] >= 8'd3 && lane[15:8] <= 8'd8) begin
                        rx_ch[i] = lane;
                    end
                end
            end
        end
        res.rf_channel      = rx_rf;
        res.channels_low    = {rx_ch[3], rx_ch[2], rx_ch[1], rx_ch[0]};
        res.channels_high   = {rx_ch[7], rx_ch[6], rx_ch[5], rx_ch[4]};
        res.packet_accepted = accepted;
        res.in_failsafe     = (rx_loss_ticks > rx_loss_limit);
        return res;
    endfunction

    // register write, mirrored into the receiver copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        case (addr)
            CFG_BOUND_ID:   rx_bound_id   = data[31:0];
            CFG_FS_LOW:     rx_fs_low     = data;
            CFG_FS_HIGH:    rx_fs_high    = data;
            CFG_LOSS_LIMIT: rx_loss_limit = data[15:0];
            CFG_UPDATE_EN:  rx_update_en  = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // hold the input until every status has come back, then let the pipe settle
    task automatic drain_status();
        s_tvalid = 1'b0;
        while (status_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // one event transfer, with random gaps ahead of it
    task automatic send_event(input logic [1:0] kind, input logic err, input logic [31:0] pid,
                              input logic [63:0] lo, input logic [63:0] hi,
                              input logic pinned, input rx_status_t status);
        int gaps;
        gaps = 0;
        while (gaps < 16 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            gaps++;
            @(negedge aclk);
        end
        s_tvalid   = 1'b1;
        s_tuser    = {err, kind};
        s_tdata    = {hi, lo, pid};
        pin_now    = pinned;
        pin_status = status;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_lane();
        if ($urandom_range(9) < 7) begin
            return {8'($urandom_range(2, 9)), 8'($urandom)};
        end
        return 16'($urandom);
    endfunction

    // random event: a slot, tick, packet or none item, its id mostly that of the bound transmitter
    task automatic send_random_event();
        int          pick;
        logic [1:0]  kind;
        logic [31:0] pid;
        logic [63:0] lo;
        logic [63:0] hi;
        pick = $urandom_range(99);
        if (pick < 25) begin
            kind = KIND_SLOT;
        end else if (pick < 60) begin
            kind = KIND_TICK;
        end else if (pick < 96) begin
            kind = KIND_PACKET;
        end else begin
            kind = KIND_NONE;
        end
        pick = $urandom_range(9);
        if (pick < 6) begin
            pid = rx_bound_id;
        end else if (pick < 8) begin
            pid = rx_bound_id ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
        end else begin
            pid = $urandom;
        end
        lo = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
        hi = {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
        send_event(kind, ($urandom_range(9) == 0), pid, lo, hi, 1'b0, '0);
    endtask

    // random settings for one phase, limits mostly kept low so timeouts happen
    task automatic write_random_config();
        int          pick;
        logic [15:0] limit;
        pick = $urandom_range(9);
        if (pick == 0) begin
            limit = 16'd0;
        end else if (pick == 1) begin
            limit = 16'hFFFF;
        end else begin
            limit = 16'($urandom_range(1, 12));
        end
        write_reg(CFG_BOUND_ID, {32'd0, 32'($urandom)});
        write_reg(CFG_FS_LOW, {32'($urandom), 32'($urandom)});
        write_reg(CFG_FS_HIGH, {32'($urandom), 32'($urandom)});
        write_reg(CFG_LOSS_LIMIT, {48'd0, limit});
        write_reg(CFG_UPDATE_EN, {63'd0, ($urandom_range(3) != 0)});
    endtask

    function automatic void plan_write(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.addr     = addr;
        row.wdata    = data;
        plan.push_back(row);
    endfunction

    function automatic void plan_event(input logic [1:0] kind, input logic err,
                                       input logic [31:0] pid, input logic [63:0] lo,
                                       input logic [63:0] hi, input logic pinned,
                                       input rx_status_t status);
        plan_row_t row;
        row = '{default: '0};
        row.kind      = kind;
        row.rx_error  = err;
        row.packet_id = pid;
        row.ch_low    = lo;
        row.ch_high   = hi;
        row.pinned    = pinned;
        row.status    = status;
        plan.push_back(row);
    endfunction

    // receiver side backpressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // run time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result check, then prediction for the event taken at this edge
    always @(posedge aclk) begin
        rx_status_t got;
        rx_status_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rf_channel      = m_tdata[7:0];
                got.channels_low    = m_tdata[71:8];
                got.channels_high   = m_tdata[135:72];
                got.packet_accepted = m_tuser[0];
                got.in_failsafe     = m_tuser[1];
                if (status_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result transfer at %0t: %h", $realtime, got);
                    end
                end else begin
                    want = status_due.pop_front();
                    if (got.rf_channel !== want.rf_channel
                            || got.channels_low !== want.channels_low
                            || got.channels_high !== want.channels_high
                            || got.packet_accepted !== want.packet_accepted
                            || got.in_failsafe !== want.in_failsafe) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch at %0t: rf %h/%h low %h/%h high %h/%h",
                                     $realtime, want.rf_channel, got.rf_channel,
                                     want.channels_low, got.channels_low,
                                     want.channels_high, got.channels_high);
                            $display("    accepted %b/%b failsafe %b/%b (expected/actual)",
                                     want.packet_accepted, got.packet_accepted,
                                     want.in_failsafe, got.in_failsafe);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = receiver_step(s_tuser[1:0], s_tuser[2], s_tdata[31:0],
                                     s_tdata[95:32], s_tdata[159:96]);
                status_due.push_back(pin_now ? pin_status : want);
            end
        end
    end

    // stimulus
    initial begin
        clear_receiver();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: hop start, filter cases, failsafe, id extremes
        plan_event(KIND_SLOT, 1'b0, 32'd0, '0, '0, 1'b1,
                   '{8'h09, RST_CH_LOW, RST_CH_HIGH, 1'b0, 1'b0});
        plan_event(KIND_TICK, 1'b0, 32'd0, '0, '0, 1'b1,
                   '{8'h09, RST_CH_LOW, RST_CH_HIGH, 1'b0, 1'b0});
        plan_event(KIND_SLOT, 1'b0, 32'd0, '0, '0, 1'b1,
                   '{8'h13, RST_CH_LOW, RST_CH_HIGH, 1'b0, 1'b0});
        plan_event(KIND_PACKET, 1'b0, 32'd0, LANES_0300, LANES_0300, 1'b1,
                   '{8'h13, LANES_0300, LANES_0300, 1'b1, 1'b0});
        // status error, then a single differing id byte
        plan_event(KIND_PACKET, 1'b1, 32'd0, {4{16'h08FF}}, {4{16'h08FF}}, 1'b1,
                   '{8'h13, LANES_0300, LANES_0300, 1'b0, 1'b0});
        plan_event(KIND_PACKET, 1'b0, 32'h0000_0100, {4{16'h0800}}, {4{16'h0800}}, 1'b1,
                   '{8'h13, LANES_0300, LANES_0300, 1'b0, 1'b0});
        // lanes at and just past the high byte window
        plan_event(KIND_PACKET, 1'b0, 32'd0, 64'h0300_08FF_0900_02FF,
                   64'h0800_0400_0000_FFFF, 1'b0, '0);
        plan_event(KIND_NONE, 1'b1, 32'hFFFF_FFFF, '1, '1, 1'b0, '0);
        plan_event(KIND_PACKET, 1'b0, 32'hFFFF_FFFF, '1, '1, 1'b0, '0);
        // offset capped, low limit, updates off
        plan_write(CFG_BOUND_ID, 64'h1234_56F3);
        plan_write(CFG_FS_LOW, 64'hFFFF_0000_1234_ABCD);
        plan_write(CFG_FS_HIGH, 64'h0000_FFFF_8000_0001);
        plan_write(CFG_LOSS_LIMIT, 64'd2);
        plan_write(CFG_UPDATE_EN, 64'd0);
        plan_event(KIND_SLOT, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_TICK, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_TICK, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_TICK, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_PACKET, 1'b0, 32'h1234_56F3, LANES_0300, LANES_0300, 1'b0, '0);
        plan_event(KIND_PACKET, 1'b0, 32'h0234_56F3, LANES_0300, LANES_0300, 1'b0, '0);
        // zero limit, all-ones id
        plan_write(CFG_LOSS_LIMIT, 64'd0);
        plan_write(CFG_UPDATE_EN, 64'd1);
        plan_write(CFG_BOUND_ID, 64'hFFFF_FFFF);
        plan_event(KIND_TICK, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_SLOT, 1'b0, 32'd0, '0, '0, 1'b0, '0);
        plan_event(KIND_PACKET, 1'b0, 32'hFFFF_FFFF, {4{16'h08FF}}, {4{16'h03AA}}, 1'b0, '0);
        plan_event(KIND_PACKET, 1'b1, 32'hFFFF_FFFF, LANES_0300, LANES_0300, 1'b0, '0);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_status();
                write_reg(plan[i].addr, plan[i].wdata);
            end else begin
                send_event(plan[i].kind, plan[i].rx_error, plan[i].packet_id,
                           plan[i].ch_low, plan[i].ch_high, plan[i].pinned, plan[i].status);
            end
        end

        // random phases, each under its own idling pattern and settings
        for (int phase = 0; phase < 4; phase++) begin
            drain_status();
            write_random_config();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int n = 0; n < 235; n++) begin
                if (phase == 2 && n == 120) begin
                    drain_status();
                end
                send_random_event();
            end
        end

        drain_status();
        repeat (10) @(negedge aclk);
        fail_count += status_due.size();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
